@@ sv/amge_pkg.sv @@
// ----------------------------------------------------------------------------
// amge_pkg
// Operation codes and fixed result-format constants for the graph engine.
// ----------------------------------------------------------------------------
package amge_pkg;

    localparam logic [3:0] F_ADDV   = 4'd0;
    localparam logic [3:0] F_REMV   = 4'd1;
    localparam logic [3:0] F_HASV   = 4'd2;
    localparam logic [3:0] F_ADDE   = 4'd3;
    localparam logic [3:0] F_REME   = 4'd4;
    localparam logic [3:0] F_HASE   = 4'd5;
    localparam logic [3:0] F_WEIGHT = 4'd6;
    localparam logic [3:0] F_NBR    = 4'd7;
    localparam logic [3:0] F_DEG    = 4'd8;
    localparam logic [3:0] F_PATH   = 4'd9;
    localparam logic [3:0] F_NV     = 4'd10;
    localparam logic [3:0] F_NE     = 4'd11;
    localparam logic [3:0] F_TOTAL  = 4'd12;
    localparam logic [3:0] F_SUCC   = 4'd13;
    localparam logic [3:0] F_PRED   = 4'd14;

    localparam int MAX_RESULTS = 16;
    localparam int NF_W        = $clog2(MAX_RESULTS + 1);
    localparam int VAL_W       = 24;
    localparam int VAL_MAX     = 8388607;
    localparam int VAL_MIN     = -8388608;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef logic [3:0] t_func;

endpackage

@@ sv/amge_mem.sv @@
// ----------------------------------------------------------------------------
// amge_mem
// Edge weight matrix: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module amge_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ sv/adjacency_matrix_graph_engine_top.sv @@
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_engine_top
// Directed weighted graph store with vertex, edge, count, list and path ops.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the edge matrix to zero with busy high.
// Vertex ops, edge writes, errors and a path query with equal ends finish
// straight from idle without a scan. All other ops walk the edge matrix
// through its single read port, one entry per cycle, reading: weight/test
// 1 entry, neighbor 2, succ/pred/nv VERTEX_COUNT, degree 2*VERTEX_COUNT,
// edge count and total VERTEX_COUNT^2. A path query reads the whole matrix
// once per pass, repeated until a pass marks no new vertex (at most
// VERTEX_COUNT passes). Results come at most one per cycle on o_valid and
// cannot be stalled; a list gives one beat per listed vertex.
module adjacency_matrix_graph_engine_top #(
    parameter int VERTEX_COUNT = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [3:0]                           i_func,
    input  logic [7:0]                           i_vertex_a,
    input  logic [7:0]                           i_vertex_b,
    input  logic signed [15:0]                   i_weight,
    output logic                                 o_valid,
    output logic                                 o_status,
    output logic signed [amge_pkg::VAL_W-1:0]    o_value,
    output logic                                 o_flag,
    output logic                                 o_last
);

    localparam int IDX_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int DEPTH = VERTEX_COUNT * VERTEX_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int ACC_W = WEIGHT_BITS + 2 * IDX_W + 2;
    localparam int SW    = (ACC_W > amge_pkg::VAL_W) ? ACC_W : amge_pkg::VAL_W;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                   r_state;
    amge_pkg::t_func              r_func;
    logic [IDX_W-1:0]             r_a, r_b;
    logic [IDX_W-1:0]             r_row, r_col;
    logic [IDX_W-1:0]             r_drow, r_dcol;
    logic                         r_issue, r_rv;
    logic signed [ACC_W-1:0]      r_acc;
    logic                         r_flag, r_grew;
    logic [VERTEX_COUNT-1:0]      r_present, r_marks;
    logic                         r_pend_v;
    logic [IDX_W-1:0]             r_pend_idx;
    logic [amge_pkg::NF_W-1:0]    r_nfound;
    logic [AW-1:0]                r_clr_addr;

    logic                         accept;
    logic                         a_bad, b_bad, err;
    logic [IDX_W-1:0]             in_a, in_b;
    logic                         we;
    logic [AW-1:0]                waddr, raddr;
    logic [WEIGHT_BITS-1:0]       wdata, rdata;
    logic signed [31:0]           w32;
    logic [IDX_W-1:0]             row_last, col_last;
    logic                         nz;

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
        addr_of = AW'(r) * AW'(VERTEX_COUNT) + AW'(c);
    endfunction

    function automatic logic signed [amge_pkg::VAL_W-1:0] sat(
        input logic signed [ACC_W-1:0] v);
        logic signed [SW-1:0] x;
        x = SW'(v);
        if (x > SW'(amge_pkg::VAL_MAX)) begin
            x = SW'(amge_pkg::VAL_MAX);
        end else if (x < SW'(amge_pkg::VAL_MIN)) begin
            x = SW'(amge_pkg::VAL_MIN);
        end
        sat = x[amge_pkg::VAL_W-1:0];
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign a_bad  = (32'(i_vertex_a) >= VERTEX_COUNT);
    assign b_bad  = (32'(i_vertex_b) >= VERTEX_COUNT);
    assign in_a   = i_vertex_a[IDX_W-1:0];
    assign in_b   = i_vertex_b[IDX_W-1:0];
    assign w32    = 32'(i_weight);
    assign nz     = |rdata;

    always_comb begin
        case (i_func)
            amge_pkg::F_ADDV, amge_pkg::F_REMV, amge_pkg::F_HASV,
            amge_pkg::F_DEG, amge_pkg::F_SUCC, amge_pkg::F_PRED: err = a_bad;
            amge_pkg::F_ADDE, amge_pkg::F_REME, amge_pkg::F_HASE,
            amge_pkg::F_WEIGHT, amge_pkg::F_NBR, amge_pkg::F_PATH: err = a_bad || b_bad;
            default: err = 1'b0;
        endcase
    end

    // scan extent per op
    always_comb begin
        case (r_func)
            amge_pkg::F_NBR: begin
                row_last = '0;
                col_last = IDX_W'(1);
            end
            amge_pkg::F_DEG: begin
                row_last = IDX_W'(1);
                col_last = IDX_W'(VERTEX_COUNT - 1);
            end
            amge_pkg::F_SUCC, amge_pkg::F_PRED, amge_pkg::F_NV: begin
                row_last = '0;
                col_last = IDX_W'(VERTEX_COUNT - 1);
            end
            amge_pkg::F_NE, amge_pkg::F_TOTAL, amge_pkg::F_PATH: begin
                row_last = IDX_W'(VERTEX_COUNT - 1);
                col_last = IDX_W'(VERTEX_COUNT - 1);
            end
            default: begin
                row_last = '0;
                col_last = '0;
            end
        endcase
    end

    always_comb begin
        case (r_func)
            amge_pkg::F_NBR:  raddr = (r_col == '0) ? addr_of(r_a, r_b) : addr_of(r_b, r_a);
            amge_pkg::F_DEG:  raddr = (r_row == '0) ? addr_of(r_a, r_col)
                                                    : addr_of(r_col, r_a);
            amge_pkg::F_SUCC: raddr = addr_of(r_a, r_col);
            amge_pkg::F_PRED: raddr = addr_of(r_col, r_a);
            amge_pkg::F_NE, amge_pkg::F_TOTAL, amge_pkg::F_PATH:
                              raddr = addr_of(r_row, r_col);
            default:          raddr = addr_of(r_a, r_b);
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = addr_of(in_a, in_b);
        wdata = w32[WEIGHT_BITS-1:0];
        if (r_state == S_CLR) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else if (accept && !err &&
                     (i_func == amge_pkg::F_ADDE || i_func == amge_pkg::F_REME)) begin
            we = 1'b1;
            if (i_func == amge_pkg::F_REME) begin
                wdata = '0;
            end
        end
    end

    amge_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (WEIGHT_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_present  <= '0;
            r_marks    <= '0;
            r_issue    <= 1'b0;
            r_rv       <= 1'b0;
            r_pend_v   <= 1'b0;
            r_nfound   <= '0;
            r_grew     <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (32'(r_clr_addr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_func   <= i_func;
                        r_a      <= in_a;
                        r_b      <= in_b;
                        r_row    <= '0;
                        r_col    <= '0;
                        r_acc    <= '0;
                        r_flag   <= 1'b0;
                        r_grew   <= 1'b0;
                        r_pend_v <= 1'b0;
                        r_nfound <= '0;
                        o_status <= amge_pkg::ST_OK;
                        o_value  <= '0;
                        o_flag   <= 1'b0;
                        o_last   <= 1'b1;
                        if (err) begin
                            o_valid  <= 1'b1;
                            o_status <= amge_pkg::ST_ERR;
                        end else begin
                            case (i_func)
                                amge_pkg::F_ADDV: begin
                                    o_valid <= 1'b1;
                                    r_present[in_a] <= 1'b1;
                                end
                                amge_pkg::F_REMV: begin
                                    o_valid <= 1'b1;
                                    r_present[in_a] <= 1'b0;
                                end
                                amge_pkg::F_HASV: begin
                                    o_valid <= 1'b1;
                                    o_flag  <= r_present[in_a];
                                end
                                amge_pkg::F_PATH: begin
                                    if (in_a == in_b) begin
                                        o_valid <= 1'b1;
                                        o_flag  <= 1'b1;
                                    end else begin
                                        r_marks[in_a] <= 1'b1;
                                        r_issue <= 1'b1;
                                        r_state <= S_SCAN;
                                    end
                                end
                                amge_pkg::F_HASE, amge_pkg::F_WEIGHT, amge_pkg::F_NBR,
                                amge_pkg::F_DEG, amge_pkg::F_NV, amge_pkg::F_NE,
                                amge_pkg::F_TOTAL, amge_pkg::F_SUCC,
                                amge_pkg::F_PRED: begin
                                    r_issue <= 1'b1;
                                    r_state <= S_SCAN;
                                end
                                default: begin
                                    o_valid <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                S_SCAN: begin
                    // read issue: data returns in the next cycle with its indices
                    r_rv   <= r_issue;
                    r_drow <= r_row;
                    r_dcol <= r_col;
                    if (r_issue) begin
                        if (r_col == col_last) begin
                            r_col <= '0;
                            if (r_row == row_last) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                    if (r_rv) begin
                        case (r_func)
                            amge_pkg::F_HASE, amge_pkg::F_NBR: begin
                                r_flag <= r_flag | nz;
                            end
                            amge_pkg::F_WEIGHT: begin
                                r_acc  <= ACC_W'($signed(rdata));
                                r_flag <= nz;
                            end
                            amge_pkg::F_DEG, amge_pkg::F_NE: begin
                                r_acc <= r_acc + ACC_W'(nz);
                            end
                            amge_pkg::F_NV: begin
                                r_acc <= r_acc + ACC_W'(r_present[r_dcol]);
                            end
                            amge_pkg::F_TOTAL: begin
                                r_acc <= r_acc + ACC_W'($signed(rdata));
                            end
                            amge_pkg::F_PATH: begin
                                if (r_marks[r_drow] && !r_marks[r_dcol] &&
                                    r_present[r_dcol] && nz) begin
                                    r_marks[r_dcol] <= 1'b1;
                                    r_grew <= 1'b1;
                                end
                            end
                            amge_pkg::F_SUCC, amge_pkg::F_PRED: begin
                                // hold one found vertex back so the final beat gets last
                                if (nz && 32'(r_nfound) < amge_pkg::MAX_RESULTS) begin
                                    if (r_pend_v) begin
                                        o_valid  <= 1'b1;
                                        o_status <= amge_pkg::ST_OK;
                                        o_value  <= amge_pkg::VAL_W'(r_pend_idx);
                                        o_flag   <= 1'b1;
                                        o_last   <= 1'b0;
                                    end
                                    r_pend_v   <= 1'b1;
                                    r_pend_idx <= r_dcol;
                                    r_nfound   <= r_nfound + 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (!r_issue && !r_rv) begin
                        if (r_func == amge_pkg::F_PATH && r_grew) begin
                            r_grew  <= 1'b0;
                            r_row   <= '0;
                            r_col   <= '0;
                            r_issue <= 1'b1;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    o_valid  <= 1'b1;
                    o_status <= amge_pkg::ST_OK;
                    o_last   <= 1'b1;
                    o_value  <= '0;
                    o_flag   <= 1'b0;
                    case (r_func)
                        amge_pkg::F_HASE, amge_pkg::F_NBR: o_flag <= r_flag;
                        amge_pkg::F_WEIGHT: begin
                            o_value <= sat(r_acc);
                            o_flag  <= r_flag;
                        end
                        amge_pkg::F_DEG, amge_pkg::F_NV, amge_pkg::F_NE,
                        amge_pkg::F_TOTAL: o_value <= sat(r_acc);
                        amge_pkg::F_PATH: o_flag <= r_marks[r_b];
                        amge_pkg::F_SUCC, amge_pkg::F_PRED: begin
                            if (r_pend_v) begin
                                o_value <= amge_pkg::VAL_W'(r_pend_idx);
                                o_flag  <= 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_marks <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_marks_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_marks == '0))
        else $error("visit marks left set while idle");

    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_CLR) |-> !o_valid)
        else $error("result beat during matrix clear");

    a_list_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nfound) <= amge_pkg::MAX_RESULTS)
        else $error("list result count beyond cap");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (o_valid && o_last))
        else $error("finishing beat missing last mark");

endmodule

@@ tb/tb_adjacency_matrix_graph_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adjacency_matrix_graph_engine_top
// Drives graph operations through the command port and checks every result
// beat against a behavioral graph model with its own presence and weight store.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_graph_engine_top;

    localparam int NVTX     = 16;
    localparam int IDLE_LIM = 200000;
    localparam int N_RAND   = 185;
    localparam amge_pkg::t_func F_NOP = 4'd15;

    typedef struct {
        logic       status;
        logic [23:0] value;
        logic       flag;
        logic       last;
    } beat_t;

    typedef struct {
        amge_pkg::t_func func;
        logic [7:0]  va;
        logic [7:0]  vb;
        logic [15:0] wt;
        bit          typed;   // expected beat given in the table
        beat_t       exp;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [3:0] i_func = '0;
    logic [7:0] i_vertex_a = '0;
    logic [7:0] i_vertex_b = '0;
    logic signed [15:0] i_weight = '0;
    logic busy, o_valid, o_status, o_flag, o_last;
    logic signed [amge_pkg::VAL_W-1:0] o_value;

    adjacency_matrix_graph_engine_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_vertex_a(i_vertex_a), .i_vertex_b(i_vertex_b),
        .i_weight(i_weight), .o_valid(o_valid), .o_status(o_status),
        .o_value(o_value), .o_flag(o_flag), .o_last(o_last)
    );

    always #10 i_clk = ~i_clk;

    bit          present[NVTX];
    logic [15:0] wmat[NVTX][NVTX];
    beat_t       pending_beats[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          beats_seen = 0;

    function automatic beat_t mk(logic s, int v, logic f, logic l);
        beat_t b;
        b.status = s; b.value = v[23:0]; b.flag = f; b.last = l;
        return b;
    endfunction

    function automatic bit reach(int a, int b);
        bit seen[NVTX];
        bit grew;
        if (a == b) return 1;
        foreach (seen[k]) seen[k] = 0;
        seen[a] = 1;
        grew = 1;
        while (grew) begin
            grew = 0;
            for (int i = 0; i < NVTX; i++) begin
                if (!seen[i]) continue;
                for (int j = 0; j < NVTX; j++) begin
                    if (!seen[j] && present[j] && wmat[i][j] != 0) begin
                        seen[j] = 1;
                        grew = 1;
                    end
                end
            end
        end
        return seen[b];
    endfunction

    // apply one operation to the graph copy and queue its result beats
    task automatic predict_graph_op(amge_pkg::t_func f, int a, int b, logic [15:0] w);
        bit uses_a, uses_b;
        int acc, n;
        logic [15:0] x;
        uses_a = (f <= amge_pkg::F_PATH) || f == amge_pkg::F_SUCC || f == amge_pkg::F_PRED;
        uses_b = (f >= amge_pkg::F_ADDE && f <= amge_pkg::F_NBR) || f == amge_pkg::F_PATH;
        if ((uses_a && a >= NVTX) || (uses_b && b >= NVTX)) begin
            pending_beats.push_back(mk(amge_pkg::ST_ERR, 0, 0, 1));
            return;
        end
        acc = 0;
        case (f)
            amge_pkg::F_ADDV: begin
                present[a] = 1;
                pending_beats.push_back(mk(amge_pkg::ST_OK, 0, 0, 1));
            end
            amge_pkg::F_REMV: begin
                present[a] = 0;
                pending_beats.push_back(mk(amge_pkg::ST_OK, 0, 0, 1));
            end
            amge_pkg::F_HASV: pending_beats.push_back(mk(amge_pkg::ST_OK, 0, present[a], 1));
            amge_pkg::F_ADDE: begin
                wmat[a][b] = w;
                pending_beats.push_back(mk(amge_pkg::ST_OK, 0, 0, 1));
            end
            amge_pkg::F_REME: begin
                wmat[a][b] = 0;
                pending_beats.push_back(mk(amge_pkg::ST_OK, 0, 0, 1));
            end
            amge_pkg::F_HASE:
                pending_beats.push_back(mk(amge_pkg::ST_OK, 0, wmat[a][b] != 0, 1));
            amge_pkg::F_WEIGHT: begin
                x = wmat[a][b];
                pending_beats.push_back(mk(amge_pkg::ST_OK, $signed(x), x != 0, 1));
            end
            amge_pkg::F_NBR:
                pending_beats.push_back(mk(amge_pkg::ST_OK, 0,
                                           wmat[a][b] != 0 || wmat[b][a] != 0, 1));
            amge_pkg::F_DEG: begin
                for (int i = 0; i < NVTX; i++)
                    acc += (wmat[a][i] != 0) + (wmat[i][a] != 0);
                pending_beats.push_back(mk(amge_pkg::ST_OK, acc, 0, 1));
            end
            amge_pkg::F_PATH: pending_beats.push_back(mk(amge_pkg::ST_OK, 0, reach(a, b), 1));
            amge_pkg::F_NV: begin
                foreach (present[i]) acc += present[i];
                pending_beats.push_back(mk(amge_pkg::ST_OK, acc, 0, 1));
            end
            amge_pkg::F_NE, amge_pkg::F_TOTAL: begin
                foreach (wmat[i, j])
                    acc += (f == amge_pkg::F_NE) ? int'(wmat[i][j] != 0)
                                                 : int'($signed(wmat[i][j]));
                pending_beats.push_back(mk(amge_pkg::ST_OK, acc, 0, 1));
            end
            amge_pkg::F_SUCC, amge_pkg::F_PRED: begin
                n = 0;
                for (int i = 0; i < NVTX && n < amge_pkg::MAX_RESULTS; i++) begin
                    x = (f == amge_pkg::F_SUCC) ? wmat[a][i] : wmat[i][a];
                    if (x != 0) begin
                        pending_beats.push_back(mk(amge_pkg::ST_OK, i, 1, 0));
                        n++;
                    end
                end
                if (n == 0) pending_beats.push_back(mk(amge_pkg::ST_OK, 0, 0, 1));
                else pending_beats[$].last = 1;
            end
            default: pending_beats.push_back(mk(amge_pkg::ST_OK, 0, 0, 1));
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_seen, what, got, want);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIM) begin
                $display("Regression FAIL");
                $finish;
            end
        end
        if (i_rst_n && o_valid) begin
            beat_t e;
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                e = pending_beats.pop_front();
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                if (o_value !== e.value)
                    report_mismatch("value", o_value, $signed(e.value));
                if (o_flag !== e.flag) report_mismatch("flag", o_flag, e.flag);
                if (o_last !== e.last) report_mismatch("last", o_last, e.last);
            end
            beats_seen++;
        end
    end

    bit no_idle = 0;

    // called at a falling edge; returns at the falling edge after the accepting beat
    task automatic send_op(amge_pkg::t_func f, logic [7:0] a, logic [7:0] b,
                           logic [15:0] w);
        while (!no_idle && $urandom_range(99) < 25) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_func <= f; i_vertex_a <= a; i_vertex_b <= b; i_weight <= w;
        start <= 1'b1;
        // busy is settled at the falling edge; the next rising edge accepts
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_graph_op(f, int'(a), int'(b), w);
        @(negedge i_clk);
    endtask

    row_t dir_rows[$];

    task automatic add_row(amge_pkg::t_func f, int a, int b, int w, bit typed = 0,
                           beat_t e = '{0, 0, 0, 0});
        row_t r;
        r.func = f; r.va = 8'(a); r.vb = 8'(b); r.wt = 16'(w); r.typed = typed; r.exp = e;
        dir_rows.push_back(r);
    endtask

    initial begin
        int k, f, a, b;
        logic [15:0] w;
        beat_t pb;
        foreach (present[i]) present[i] = 0;
        foreach (wmat[i, j]) wmat[i][j] = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(amge_pkg::F_NV, 0, 0, 0, 1, mk(amge_pkg::ST_OK, 0, 0, 1));
        add_row(amge_pkg::F_NE, 0, 0, 0, 1, mk(amge_pkg::ST_OK, 0, 0, 1));
        add_row(amge_pkg::F_SUCC, 0, 0, 0, 1, mk(amge_pkg::ST_OK, 0, 0, 1));
        add_row(amge_pkg::F_ADDV, 255, 0, 0, 1, mk(amge_pkg::ST_ERR, 0, 0, 1));
        add_row(amge_pkg::F_ADDE, 3, 16, 5, 1, mk(amge_pkg::ST_ERR, 0, 0, 1));
        add_row(amge_pkg::F_PATH, 16, 3, 0, 1, mk(amge_pkg::ST_ERR, 0, 0, 1));
        add_row(F_NOP, 255, 255, 16'hffff, 1, mk(amge_pkg::ST_OK, 0, 0, 1));
        add_row(amge_pkg::F_PATH, 7, 7, 0, 1, mk(amge_pkg::ST_OK, 0, 1, 1)); // equal ends, absent
        add_row(amge_pkg::F_ADDV, 0, 0, 0);
        add_row(amge_pkg::F_ADDV, 15, 0, 0);
        add_row(amge_pkg::F_ADDE, 0, 15, 16'h7fff);
        add_row(amge_pkg::F_ADDE, 15, 15, 16'h8000);                       // self-loop
        add_row(amge_pkg::F_ADDE, 15, 0, 16'hffff);
        add_row(amge_pkg::F_WEIGHT, 15, 15, 0, 1, mk(amge_pkg::ST_OK, -32768, 1, 1));
        add_row(amge_pkg::F_WEIGHT, 3, 4, 0, 1, mk(amge_pkg::ST_OK, 0, 0, 1));
        add_row(amge_pkg::F_DEG, 15, 0, 0);
        add_row(amge_pkg::F_HASE, 0, 15, 0);
        add_row(amge_pkg::F_NBR, 15, 0, 0);
        add_row(amge_pkg::F_PATH, 0, 15, 0);
        add_row(amge_pkg::F_REMV, 15, 0, 0);
        add_row(amge_pkg::F_PATH, 0, 15, 0);                              // target absent
        add_row(amge_pkg::F_HASV, 15, 0, 0);
        add_row(amge_pkg::F_TOTAL, 0, 0, 0);
        add_row(amge_pkg::F_PRED, 15, 0, 0);
        add_row(amge_pkg::F_REME, 15, 15, 0);
        foreach (dir_rows[i]) begin
            send_op(dir_rows[i].func, dir_rows[i].va, dir_rows[i].vb, dir_rows[i].wt);
            if (dir_rows[i].typed) begin
                // the typed beat must agree with the graph copy too
                pb = pending_beats[$];
                if (pb.status !== dir_rows[i].exp.status ||
                    pb.value !== dir_rows[i].exp.value ||
                    pb.flag !== dir_rows[i].exp.flag ||
                    pb.last !== dir_rows[i].exp.last)
                    report_mismatch("table row", i, i);
            end
        end

        for (k = 0; k < N_RAND; k++) begin
            if (k == 60) begin
                // drain before continuing
                start <= 1'b0;
                @(negedge i_clk);
                while (pending_beats.size() != 0) @(negedge i_clk);
            end
            no_idle = (k >= 100 && k < 140);
            f = $urandom_range(99);
            if (f < 30) f = int'(amge_pkg::F_ADDE);
            else if (f < 40) f = int'(amge_pkg::F_ADDV);
            else if (f < 45) f = int'(amge_pkg::F_REMV);
            else if (f < 50) f = int'(amge_pkg::F_REME);
            else f = $urandom_range(15);
            a = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(NVTX - 1);
            b = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(NVTX - 1);
            w = 16'($urandom);
            if ($urandom_range(9) == 0) w = 0;
            send_op(amge_pkg::t_func'(f), 8'(a), 8'(b), w);
        end

        start <= 1'b0;
        @(negedge i_clk);
        k = 0;
        while (pending_beats.size() != 0 && k < IDLE_LIM) begin
            @(negedge i_clk);
            k++;
        end
        repeat (3000) @(negedge i_clk);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
